/* hdl/tsf_pkg.sv */
// Shared types, constants and helper functions for the Tanimoto similarity filter.
`default_nettype none

package tsf_pkg;

  localparam int CountWidth = 12;
  localparam int QuoWidth   = 17;
  localparam int ThrWidth   = 17;
  localparam int PosWidth   = 40;
  localparam int WordWidth  = 32;
  localparam int PcWidth    = 6;
  localparam int ProdWidth  = ThrWidth + CountWidth;
  localparam int StepWidth  = 5;
  localparam int FracBits   = 16;

  localparam logic [CountWidth-1:0] CountSat  = '1;
  localparam logic [StepWidth-1:0]  LastStep  = StepWidth'(QuoWidth - 1);

  // Register indexes on the configuration port
  localparam logic REG_MIN_SIM = 1'b0;
  localparam logic REG_MAX_SIM = 1'b1;

  localparam logic [ThrWidth-1:0] MaxSimReset = 17'd65537;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DIV,
    ST_LOAD
  } tsf_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic acc;
    logic start;
    logic step;
    logic load;
  } tsf_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_busy;
  } tsf_stat_t;

  // Count set bits of one word: byte sums, then a small add tree
  function automatic logic [PcWidth-1:0] popcount32(input logic [WordWidth-1:0] w);
    logic [3:0] byte_cnt [4];
    logic [PcWidth-1:0] total;
    for (int b = 0; b < 4; b++) begin
      byte_cnt[b] = '0;
      for (int i = 0; i < 8; i++) begin
        byte_cnt[b] = byte_cnt[b] + {3'b000, w[b*8+i]};
      end
    end
    total = ({2'b00, byte_cnt[0]} + {2'b00, byte_cnt[1]}) +
            ({2'b00, byte_cnt[2]} + {2'b00, byte_cnt[3]});
    return total;
  endfunction

  // Add a word count to a running count, clamped at the top value
  function automatic logic [CountWidth-1:0] sat_add(input logic [CountWidth-1:0] acc,
                                                    input logic [PcWidth-1:0] inc);
    logic [CountWidth:0] sum;
    sum = {1'b0, acc} + {{(CountWidth+1-PcWidth){1'b0}}, inc};
    return sum[CountWidth] ? CountSat : sum[CountWidth-1:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/tsf_ctrl.sv */
// Controller state machine: accumulate words, run the divider, hand off the result.
`default_nettype none

module tsf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             last_word,
  output logic                  in_ready,
  input  wire tsf_pkg::tsf_stat_t stat,
  output tsf_pkg::tsf_cmd_t     cmd
);

  tsf_pkg::tsf_state_t state, state_next;
  logic [tsf_pkg::StepWidth-1:0] step_cnt, step_cnt_next;

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tsf_pkg::ST_ACC;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state)
      tsf_pkg::ST_ACC: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (last_word) begin
            cmd.start     = 1'b1;
            step_cnt_next = tsf_pkg::LastStep;
            state_next    = tsf_pkg::ST_DIV;
          end
        end
      end
      tsf_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (step_cnt == '0) begin
          state_next = tsf_pkg::ST_LOAD;
        end else begin
          step_cnt_next = step_cnt - 1'b1;
        end
      end
      tsf_pkg::ST_LOAD: begin
        if (!stat.out_busy) begin
          cmd.load   = 1'b1;
          state_next = tsf_pkg::ST_ACC;
        end
      end
      default: begin
        state_next = tsf_pkg::ST_ACC;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/tsf_dp.sv */
// Datapath: popcount accumulators, bit-serial divider, threshold products, output register.
`default_nettype none

module tsf_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire tsf_pkg::tsf_cmd_t               cmd,
  output tsf_pkg::tsf_stat_t                   stat,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [tsf_pkg::ThrWidth-1:0]    cfg_data,
  input  wire logic [tsf_pkg::WordWidth-1:0]   query_word,
  input  wire logic [tsf_pkg::WordWidth-1:0]   entry_word,
  input  wire logic [tsf_pkg::PosWidth-1:0]    seek_position,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [tsf_pkg::CountWidth-1:0]       common_bits,
  output logic [tsf_pkg::CountWidth-1:0]       union_bits,
  output logic [tsf_pkg::QuoWidth-1:0]         similarity,
  output logic                                 in_range,
  output logic [tsf_pkg::PosWidth-1:0]         entry_position
);

  logic [tsf_pkg::ThrWidth-1:0]   min_similarity, max_similarity;
  logic [tsf_pkg::CountWidth-1:0] and_count, or_count;
  logic [tsf_pkg::CountWidth-1:0] and_sum, or_sum;
  logic [tsf_pkg::CountWidth-1:0] div_and, div_or;
  logic [tsf_pkg::CountWidth:0]   rem;
  logic [tsf_pkg::QuoWidth-1:0]   quo;
  logic [tsf_pkg::PosWidth-1:0]   pos_hold;
  logic [tsf_pkg::ProdWidth-1:0]  lo_prod, hi_prod;
  logic [tsf_pkg::ProdWidth-1:0]  scaled;
  logic                           rem_ge;
  logic [tsf_pkg::CountWidth:0]   rem_sub;

  // Running sums including the word now offered
  assign and_sum = tsf_pkg::sat_add(and_count, tsf_pkg::popcount32(query_word & entry_word));
  assign or_sum  = tsf_pkg::sat_add(or_count, tsf_pkg::popcount32(query_word | entry_word));

  // Threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_similarity <= '0;
      max_similarity <= tsf_pkg::MaxSimReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsf_pkg::REG_MIN_SIM: min_similarity <= cfg_data;
        tsf_pkg::REG_MAX_SIM: max_similarity <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accumulate counts; clear them when the last word starts a division
  always_ff @(posedge clk) begin
    if (rst) begin
      and_count <= '0;
      or_count  <= '0;
    end else if (cmd.start) begin
      and_count <= '0;
      or_count  <= '0;
    end else if (cmd.acc) begin
      and_count <= and_sum;
      or_count  <= or_sum;
    end
  end

  // One quotient bit a step: compare, subtract, shift
  assign rem_ge  = rem >= {1'b0, div_or};
  assign rem_sub = rem_ge ? (rem - {1'b0, div_or}) : rem;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      div_and  <= and_sum;
      div_or   <= or_sum;
      rem      <= {1'b0, and_sum};
      quo      <= '0;
      pos_hold <= seek_position;
    end else if (cmd.step) begin
      rem <= {rem_sub[tsf_pkg::CountWidth-1:0], 1'b0};
      quo <= {quo[tsf_pkg::QuoWidth-2:0], rem_ge};
    end
  end

  // Threshold products, registered while the divider runs
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      lo_prod <= min_similarity * div_or;
      hi_prod <= max_similarity * div_or;
    end
  end

  assign scaled = {{(tsf_pkg::ProdWidth-tsf_pkg::CountWidth-tsf_pkg::FracBits){1'b0}},
                   div_and, {tsf_pkg::FracBits{1'b0}}};

  // Output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      common_bits    <= div_and;
      union_bits     <= div_or;
      similarity     <= (div_or == '0) ? '0 : quo;
      in_range       <= (scaled > lo_prod) && (scaled < hi_prod);
      entry_position <= pos_hold;
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

endmodule

`default_nettype wire

/* hdl/tanimoto_similarity_filter.sv */
// Top level of the Tanimoto similarity filter: controller plus datapath.
//
//  channel | signals                         | payload
//  --------+---------------------------------+----------------------------------------------
//  in      | in_valid / in_ready             | query_word, entry_word, seek_position, last_word
//  out     | out_valid / out_ready           | common_bits, union_bits, similarity, in_range,
//          |                                 | entry_position
//  cfg     | cfg_we, cfg_index, cfg_data     | min_similarity (0), max_similarity (1)
//
// A word that is not last only adds to the counts. A last word also starts
// the shift-subtract divider (one quotient bit per cycle) and is followed
// by a load of the output register; no word is taken until that load.
// The load waits while the previous result word is still held in the output register.
// Reset clears the counts, the thresholds (to 0 and 65537) and out_valid.
`default_nettype none

module tanimoto_similarity_filter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [tsf_pkg::ThrWidth-1:0]  cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tsf_pkg::WordWidth-1:0] query_word,
  input  wire logic [tsf_pkg::WordWidth-1:0] entry_word,
  input  wire logic [tsf_pkg::PosWidth-1:0]  seek_position,
  input  wire logic                          last_word,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [tsf_pkg::CountWidth-1:0]     common_bits,
  output logic [tsf_pkg::CountWidth-1:0]     union_bits,
  output logic [tsf_pkg::QuoWidth-1:0]       similarity,
  output logic                               in_range,
  output logic [tsf_pkg::PosWidth-1:0]       entry_position
);

  tsf_pkg::tsf_cmd_t  cmd;
  tsf_pkg::tsf_stat_t stat;

  tsf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_word (last_word),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tsf_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .query_word     (query_word),
    .entry_word     (entry_word),
    .seek_position  (seek_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .common_bits    (common_bits),
    .union_bits     (union_bits),
    .similarity     (similarity),
    .in_range       (in_range),
    .entry_position (entry_position)
  );

  // Ratio never exceeds one
  a_sim_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> similarity <= 17'd65536)
    else $error("similarity above 1.0");

  // Intersection never exceeds union
  a_count_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> common_bits <= union_bits)
    else $error("common_bits above union_bits");

  // Empty union gives zero ratio and no match
  a_empty_union: assert property (@(posedge clk) disable iff (rst)
    (out_valid && union_bits == '0) |-> (similarity == '0 && !in_range))
    else $error("empty union result not zero");

  // No word taken while the divider runs
  a_no_accept_div: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !in_ready)
    else $error("input accepted during division");

endmodule

`default_nettype wire
